FILE: hw/rtl/ppt_pkg.sv
// Shared constants and types for the pulse period tachometer.
`timescale 1ns / 1ps
package ppt_pkg;

	localparam int unsigned TIME_W = 32;
	localparam int unsigned PPR_W  = 8;
	localparam int unsigned DVSR_W = TIME_W + PPR_W;   // elapsed * pulses_per_rev
	localparam int unsigned QUO_W  = 33;               // speed in hundredths of RPM
	localparam int unsigned CNT_W  = $clog2(QUO_W);

	// 100 * 60 * 1e6: hundredths of a minute in microseconds
	localparam logic [QUO_W-1:0] SPEED_DIVIDEND = 33'd6000000000;

	localparam logic [PPR_W-1:0] PPR_RESET = 8'd20;

	localparam int unsigned S_TDATA_W = 40;
	localparam int unsigned M_TDATA_W = 72;

	// divider status toward the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} ppt_div_stat_t;

	// sequencer states, one-hot
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_MUL  = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_DONE = 4'b1000
	} ppt_state_t;

endpackage

FILE: hw/rtl/ppt_div.sv
// Restoring serial divider: constant dividend by a 40-bit divisor, one quotient bit per cycle.
`timescale 1ns / 1ps
module ppt_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [ppt_pkg::DVSR_W-1:0]    divisor,
	output ppt_pkg::ppt_div_stat_t        stat,
	output logic [ppt_pkg::QUO_W-1:0]     quotient
);

	logic                         busy_q;
	logic                         done_q;
	logic [ppt_pkg::CNT_W-1:0]    cnt_q;
	logic [ppt_pkg::DVSR_W-1:0]   rem_q;
	logic [ppt_pkg::QUO_W-1:0]    quo_q;
	logic [ppt_pkg::DVSR_W-1:0]   dvsr_q;
	logic [ppt_pkg::DVSR_W:0]     shifted;
	logic [ppt_pkg::DVSR_W+1:0]   diff;

	// trial subtract of the shifted partial remainder
	assign shifted = {rem_q, quo_q[ppt_pkg::QUO_W-1]};
	assign diff    = {1'b0, shifted} - {2'b00, dvsr_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == ppt_pkg::CNT_W'(ppt_pkg::QUO_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			quo_q  <= ppt_pkg::SPEED_DIVIDEND;
			dvsr_q <= divisor;
		end else if (busy_q) begin
			if (!diff[ppt_pkg::DVSR_W+1]) begin
				rem_q <= diff[ppt_pkg::DVSR_W-1:0];
				quo_q <= {quo_q[ppt_pkg::QUO_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[ppt_pkg::DVSR_W-1:0];
				quo_q <= {quo_q[ppt_pkg::QUO_W-2:0], 1'b0};
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;

endmodule

FILE: hw/rtl/pulse_period_tachometer.sv
// Top level: edge detect, period capture, sequencer and result register.
//
//  channel  | dir | fields (low bit first)              | handshake
//  s_axis   | in  | sensor_level[0], time_us[32:1]       | tvalid/tready
//  m_axis   | out | rpm_hundredths[32:0], period_us[64:33] | tvalid/tready
//  cfg      | in  | pulses_per_rev[7:0]                  | cfg_we
//
// A poll with no rising edge, or with zero elapsed time, leaves the sequencer in IDLE.
// A rising edge passes through accept, one multiply, the divider start,
// 33 divider steps (one quotient bit per cycle), the done cycle and the result load.
// Reset clears level, edge time and pulses_per_rev (to 20); no clearing pass.
// The result waits in its register; the next poll is taken meanwhile, and a
// finished divide holds in DONE until the result register is free.
`timescale 1ns / 1ps
module pulse_period_tachometer (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [ppt_pkg::S_TDATA_W-1:0]     s_axis_tdata,  // sensor_level, time_us, pad
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [ppt_pkg::M_TDATA_W-1:0]     m_axis_tdata,  // rpm_hundredths, period_us, pad
	input  logic                              cfg_we,
	input  logic [ppt_pkg::PPR_W-1:0]         cfg_wdata
);

	ppt_pkg::ppt_state_t            state_q;
	logic                           prev_level_q;
	logic [ppt_pkg::TIME_W-1:0]     last_edge_q;
	logic [ppt_pkg::PPR_W-1:0]      ppr_q;
	logic [ppt_pkg::TIME_W-1:0]     elapsed_q;
	logic [ppt_pkg::DVSR_W-1:0]     divisor_q;
	logic                           div_start_q;
	logic                           out_valid_q;
	logic [ppt_pkg::QUO_W-1:0]      out_rpm_q;
	logic [ppt_pkg::TIME_W-1:0]     out_period_q;

	logic                           in_level;
	logic [ppt_pkg::TIME_W-1:0]     in_time;
	logic [ppt_pkg::TIME_W-1:0]     elapsed;
	logic                           accept;
	logic                           rise;
	logic [ppt_pkg::PPR_W-1:0]      ppr_eff;
	logic                           out_free;
	ppt_pkg::ppt_div_stat_t         div_stat;
	logic [ppt_pkg::QUO_W-1:0]      div_quo;

	assign in_level = s_axis_tdata[0];
	assign in_time  = s_axis_tdata[ppt_pkg::TIME_W:1];
	assign elapsed  = in_time - last_edge_q;
	assign s_axis_tready = (state_q == ppt_pkg::ST_IDLE);
	assign accept   = s_axis_tvalid && s_axis_tready;
	assign rise     = in_level && !prev_level_q;
	assign ppr_eff  = (ppr_q == '0) ? ppt_pkg::PPR_W'(1) : ppr_q;
	assign out_free = !out_valid_q || m_axis_tready;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ppr_q <= ppt_pkg::PPR_RESET;
		end else if (cfg_we) begin
			ppr_q <= cfg_wdata;
		end
	end

	// sequencer and tachometer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ppt_pkg::ST_IDLE;
			prev_level_q <= 1'b0;
			last_edge_q  <= '0;
			div_start_q  <= 1'b0;
		end else begin
			div_start_q <= 1'b0;
			case (state_q)
				ppt_pkg::ST_IDLE: begin
					if (accept) begin
						prev_level_q <= in_level;
						if (rise) begin
							last_edge_q <= in_time;
							if (elapsed != '0) begin
								state_q <= ppt_pkg::ST_MUL;
							end
						end
					end
				end
				ppt_pkg::ST_MUL: begin
					div_start_q <= 1'b1;
					state_q     <= ppt_pkg::ST_DIV;
				end
				ppt_pkg::ST_DIV: begin
					if (div_stat.done) begin
						state_q <= ppt_pkg::ST_DONE;
					end
				end
				ppt_pkg::ST_DONE: begin
					if (out_free) begin
						state_q <= ppt_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= ppt_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// period capture and divisor product
	always_ff @(posedge clk) begin
		if (accept && rise) begin
			elapsed_q <= elapsed;
		end
		if (state_q == ppt_pkg::ST_MUL) begin
			divisor_q <= elapsed_q * ppr_eff;
		end
	end

	ppt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.divisor  (divisor_q),
		.stat     (div_stat),
		.quotient (div_quo)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ppt_pkg::ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ppt_pkg::ST_DONE && out_free) begin
			out_rpm_q    <= div_quo;
			out_period_q <= elapsed_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, out_period_q, out_rpm_q};

`ifndef SYNTH
	// no poll is taken while the divider runs
	a_ready_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !div_stat.busy)
		else $error("poll accepted while divider busy");

	// divider completes only while the sequencer waits for it
	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> (state_q == ppt_pkg::ST_DIV))
		else $error("divider done outside DIV");

	// a reported period is never zero
	a_period_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[64:33] != '0))
		else $error("zero period reported");

	// a new result comes only out of the DONE state
	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q == ppt_pkg::ST_DONE))
		else $error("result loaded outside DONE");
`endif

endmodule
